>>> rtl/max_heap_priority_queue_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the max-heap priority queue checker.
// Each macro expands to one labeled concurrent assertion that reports by $error.
// ---------------------------------------------------------------------------
`ifndef MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MHPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MHPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mhpq_pkg.sv
// ---------------------------------------------------------------------------
// mhpq_pkg
// Shared types, codes and default sizes for the max-heap priority queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mhpq_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int DEF_CAPACITY    = 128;
    localparam int DEF_VALUE_WIDTH = 16;

    // Fixed widths of the request and result fields.
    localparam int PRIO_W   = 16;
    localparam int STATUS_W = 2;
    localparam int MAX_W    = 16;
    localparam int OCC_W    = 8;

    // Request command codes.
    typedef enum logic {
        CMD_INSERT  = 1'b0,
        CMD_EXTRACT = 1'b1
    } cmd_code_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_READ,
        ST_UP_CMP,
        ST_EXT_LOAD,
        ST_DN_READ,
        ST_DN_CMP,
        ST_RESP
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ins_start;  // load new value, hole at the end, count up
        logic set_full;   // refuse insert
        logic set_empty;  // refuse extract
        logic ext_start;  // read root and last entry, count down
        logic ext_load;   // capture root as result, last entry as moving value
        logic up_read;    // read the parent of the hole
        logic up_move;    // move the parent down into the hole
        logic dn_read;    // read both children of the hole
        logic dn_move;    // move the larger child up into the hole
        logic place;      // write the moving value into the hole
        logic out_load;   // load the result register
    } mhpq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic at_root;
        logic leaf;
        logic up_more;
        logic dn_more;
        logic out_free;
    } mhpq_sts_t;

endpackage

>>> rtl/mhpq_ctrl.sv
// ---------------------------------------------------------------------------
// mhpq_ctrl
// Controller for the heap: accepts one request at a time and steps the
// datapath through sift-up or sift-down, a read state and a compare state per tree level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mhpq_ctrl
    import mhpq_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  logic      s_command,
    input  mhpq_sts_t sts,
    output mhpq_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                // Requests are taken only while out of reset.
                s_ready = aresetn;
                if (s_valid && aresetn) begin
                    case (cmd_code_t'(s_command))
                        CMD_INSERT: begin
                            if (sts.full) begin
                                cmd.set_full = 1'b1;
                                state_next   = ST_RESP;
                            end else begin
                                cmd.ins_start = 1'b1;
                                state_next    = ST_UP_READ;
                            end
                        end
                        CMD_EXTRACT: begin
                            if (sts.empty) begin
                                cmd.set_empty = 1'b1;
                                state_next    = ST_RESP;
                            end else begin
                                cmd.ext_start = 1'b1;
                                state_next    = ST_EXT_LOAD;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_UP_READ: begin
                if (sts.at_root) begin
                    cmd.place  = 1'b1;
                    state_next = ST_RESP;
                end else begin
                    cmd.up_read = 1'b1;
                    state_next  = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                if (sts.up_more) begin
                    cmd.up_move = 1'b1;
                    state_next  = ST_UP_READ;
                end else begin
                    cmd.place  = 1'b1;
                    state_next = ST_RESP;
                end
            end
            ST_EXT_LOAD: begin
                cmd.ext_load = 1'b1;
                // The heap is left empty when the last element was taken.
                if (sts.empty) begin
                    state_next = ST_RESP;
                end else begin
                    state_next = ST_DN_READ;
                end
            end
            ST_DN_READ: begin
                if (sts.leaf) begin
                    cmd.place  = 1'b1;
                    state_next = ST_RESP;
                end else begin
                    cmd.dn_read = 1'b1;
                    state_next  = ST_DN_CMP;
                end
            end
            ST_DN_CMP: begin
                if (sts.dn_more) begin
                    cmd.dn_move = 1'b1;
                    state_next  = ST_DN_READ;
                end else begin
                    cmd.place  = 1'b1;
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/mhpq_datapath.sv
// ---------------------------------------------------------------------------
// mhpq_datapath
// Heap memory, element count, hole position and moving value, compare logic
// and the result register of the max-heap priority queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mhpq_datapath
    import mhpq_pkg::*;
#(
    parameter int CAPACITY    = DEF_CAPACITY,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
)
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [PRIO_W-1:0]   s_priority_req,
    input  mhpq_cmd_t           cmd,
    output mhpq_sts_t           sts,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [MAX_W-1:0]    m_max_value,
    output logic [OCC_W-1:0]    m_occupancy
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CHW   = IDX_W + 2;

    // Heap storage; entries beyond the count are never read for a decision.
    logic [VALUE_WIDTH-1:0] heap_mem [CAPACITY];

    logic [CNT_W-1:0]       count_reg;
    logic [IDX_W-1:0]       pos_reg;
    logic [VALUE_WIDTH-1:0] hold_reg;
    logic [VALUE_WIDTH-1:0] rd0_reg;
    logic [VALUE_WIDTH-1:0] rd1_reg;
    status_t                status_reg;
    logic [MAX_W-1:0]       max_reg;

    logic                   m_valid_reg;
    status_t                m_status_reg;
    logic [MAX_W-1:0]       m_max_value_reg;
    logic [OCC_W-1:0]       m_occupancy_reg;

    logic [IDX_W-1:0]       pos_dec;
    logic [IDX_W-1:0]       parent_idx;
    logic [CHW-1:0]         left_idx;
    logic [CHW-1:0]         right_idx;
    logic [CHW-1:0]         count_ext;
    logic                   pick_right;
    logic [VALUE_WIDTH-1:0] best_val;
    logic [CHW-1:0]         best_idx;
    logic [IDX_W-1:0]       rd_addr0;
    logic [IDX_W-1:0]       rd_addr1;
    logic                   wr_en;
    logic [VALUE_WIDTH-1:0] wr_data;
    logic [31:0]            prio_ext;
    logic [31:0]            root_ext;
    logic [31:0]            count_ext32;

    // Tree navigation around the hole.
    assign pos_dec    = pos_reg - 1'b1;
    assign parent_idx = pos_dec >> 1;
    assign left_idx   = {1'b0, pos_reg, 1'b1};
    assign right_idx  = left_idx + 1'b1;
    assign count_ext  = CHW'(count_reg);

    // Larger child; the left one wins a tie.
    assign pick_right = (right_idx < count_ext) && (rd1_reg > rd0_reg);
    assign best_val   = pick_right ? rd1_reg : rd0_reg;
    assign best_idx   = pick_right ? right_idx : left_idx;

    // Field width adaptation.
    assign prio_ext    = 32'(s_priority_req);
    assign root_ext    = 32'(rd0_reg);
    assign count_ext32 = 32'(count_reg);

    // Read addresses: parent on sift-up, children on sift-down,
    // otherwise root and last element for an extract.
    always_comb begin
        rd_addr0 = '0;
        rd_addr1 = IDX_W'(count_reg - 1'b1);
        if (cmd.up_read) begin
            rd_addr0 = parent_idx;
        end else if (cmd.dn_read) begin
            rd_addr0 = left_idx[IDX_W-1:0];
            rd_addr1 = right_idx[IDX_W-1:0];
        end
    end

    // Single write port, always at the hole.
    assign wr_en   = cmd.up_move | cmd.dn_move | cmd.place;
    always_comb begin
        wr_data = hold_reg;
        if (cmd.up_move) begin
            wr_data = rd0_reg;
        end else if (cmd.dn_move) begin
            wr_data = best_val;
        end
    end

    // Heap memory with two registered read ports.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            heap_mem[pos_reg] <= wr_data;
        end
        rd0_reg <= heap_mem[rd_addr0];
        rd1_reg <= heap_mem[rd_addr1];
    end

    // Element count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.ins_start) begin
            count_reg <= count_reg + 1'b1;
        end else if (cmd.ext_start) begin
            count_reg <= count_reg - 1'b1;
        end
    end

    // Hole position, moving value and per-request result.
    always_ff @(posedge aclk) begin
        if (cmd.ins_start) begin
            pos_reg  <= IDX_W'(count_reg);
            hold_reg <= prio_ext[VALUE_WIDTH-1:0];
        end else if (cmd.ext_load) begin
            pos_reg  <= '0;
            hold_reg <= rd1_reg;
        end else if (cmd.up_move) begin
            pos_reg <= parent_idx;
        end else if (cmd.dn_move) begin
            pos_reg <= best_idx[IDX_W-1:0];
        end

        if (cmd.ins_start || cmd.ext_start) begin
            status_reg <= STATUS_DONE;
            max_reg    <= '0;
        end else if (cmd.set_full) begin
            status_reg <= STATUS_FULL;
            max_reg    <= '0;
        end else if (cmd.set_empty) begin
            status_reg <= STATUS_EMPTY;
            max_reg    <= '0;
        end else if (cmd.ext_load) begin
            max_reg <= root_ext[MAX_W-1:0];
        end
    end

    // Result register; it frees up in the cycle its request is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_status_reg    <= status_reg;
            m_max_value_reg <= max_reg;
            m_occupancy_reg <= count_ext32[OCC_W-1:0];
        end
    end

    // Status toward the controller.
    assign sts.full     = (count_reg == CNT_W'(CAPACITY));
    assign sts.empty    = (count_reg == '0);
    assign sts.at_root  = (pos_reg == '0);
    assign sts.leaf     = (left_idx >= count_ext);
    assign sts.up_more  = (hold_reg > rd0_reg);
    assign sts.dn_more  = (best_val > hold_reg);
    assign sts.out_free = !m_valid_reg || m_ready;

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_max_value = m_max_value_reg;
    assign m_occupancy = m_occupancy_reg;

endmodule

>>> rtl/max_heap_priority_queue.sv
// ---------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap priority queue. Each request either inserts a priority
// (command 0) or extracts the largest held priority (command 1), and each
// request gets exactly one result with a status, the extracted value (zero
// unless an extract succeeds) and the element count after the request.
// Insert on a full heap and extract on an empty heap are refused and change
// nothing. Requests are handled one at a time. The sift loop does one heap
// memory read and one compare per tree level, in separate states because
// the memory read data is registered.
// A new request is taken while the previous result still waits in the
// output register. No clearing pass is needed after reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module max_heap_priority_queue
    import mhpq_pkg::*;
#(
    parameter int CAPACITY    = DEF_CAPACITY,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
)
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_command,
    input  logic [PRIO_W-1:0]   s_priority_req,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [MAX_W-1:0]    m_max_value,
    output logic [OCC_W-1:0]    m_occupancy
);

    mhpq_cmd_t cmd;
    mhpq_sts_t sts;

    // Request sequencing.
    mhpq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Heap storage and result path.
    mhpq_datapath #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_priority_req (s_priority_req),
        .cmd            (cmd),
        .sts            (sts),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_max_value    (m_max_value),
        .m_occupancy    (m_occupancy)
    );

endmodule

>>> rtl/mhpq_checker.sv
// ---------------------------------------------------------------------------
// mhpq_checker
// Port-level checks for the max-heap priority queue, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "max_heap_priority_queue_assert.svh"

module mhpq_checker
    import mhpq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [STATUS_W-1:0] m_status,
    input logic [MAX_W-1:0]    m_max_value,
    input logic [OCC_W-1:0]    m_occupancy
);

    localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(CAPACITY);

    // A stalled result keeps its contents.
    `MHPQ_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_max_value) && $stable(m_occupancy), "stalled result changed")

    // Only a successful extract reports a nonzero value.
    `MHPQ_ASSERT_NOW(a_refused_zero, aclk, aresetn, m_valid && (m_status != STATUS_DONE), m_max_value == '0, "refused request returned a value")

    // A full refusal reports the full count, an empty refusal an empty heap.
    `MHPQ_ASSERT_NOW(a_full_count, aclk, aresetn, m_valid && (m_status == STATUS_FULL), m_occupancy == FULL_OCC, "full refusal with wrong occupancy")
    `MHPQ_ASSERT_NOW(a_empty_count, aclk, aresetn, m_valid && (m_status == STATUS_EMPTY), m_occupancy == '0, "empty refusal with nonzero occupancy")

    // One request at a time: acceptance is always followed by a busy cycle.
    `MHPQ_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready, "request accepted back to back")

endmodule

bind max_heap_priority_queue mhpq_checker #(
    .CAPACITY (CAPACITY)
) u_mhpq_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_status    (m_status),
    .m_max_value (m_max_value),
    .m_occupancy (m_occupancy)
);
